FILE: sv/rrstc_pkg.sv
// Package with the item types, register indexes and constants of the row range-sum counter.
package rrstc_pkg;

   localparam int ROW_W        = 8;
   localparam int COL_W        = 11;
   localparam int VAL_W        = 16;
   localparam int ENTRY_W      = 27;
   localparam int CNT_W        = 8;
   localparam int DATA_W       = 32;
   localparam int CSR_ADDR_W   = 4;
   localparam int DEF_MAX_ROWS = 128;
   localparam int DEF_MAX_COLS = 1024;

   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_ROW_COUNT = 2'd1;
   localparam logic [1:0] REG_COL_COUNT = 2'd2;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef struct packed {
      logic                    action;
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic signed [VAL_W-1:0] value;
      logic [COL_W-1:0]        left;
      logic [COL_W-1:0]        right;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0] above_count;
      logic [CNT_W-1:0] not_above_count;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] threshold;
      logic [ROW_W-1:0]         row_count;
      logic [COL_W-1:0]         col_count;
   } cfg_type;

endpackage

FILE: sv/row_range_sum_threshold_count.sv
// Top level of the row range-sum threshold counter.
//
// An item is taken when start is high and busy is low; req_data carries it.
// A load item adds its value to the previous column's prefix of its row and
// stores the sum in the prefix table. It gives no result.
// A load outside the configured rows or columns is dropped.
// A query item walks the configured rows, reading both prefix entries of a
// row together from the two read ports of the table memory. Its result
// appears when the walk is over and the read and difference registers have
// drained, and the next item can be taken from then on. With no rows in use
// the result appears in the next cycle and busy stays low.
// The result is on rsp_data for one cycle while rsp_valid is high; the
// receiver cannot stall it, and busy falls as the result appears.
// Registers threshold, row_count and col_count sit at byte addresses 0, 4
// and 8 of the APB-style port, which is always ready.
// Reset returns the sequencer to idle and the registers to their defaults.
// The table is not cleared: each row must be loaded from column one upward
// before it is queried.
module row_range_sum_threshold_count #(
   parameter int MAX_ROWS = rrstc_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = rrstc_pkg::DEF_MAX_COLS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  rrstc_pkg::req_type                 req_data,
   output logic                               rsp_valid,
   output rrstc_pkg::rsp_type                 rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rrstc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [rrstc_pkg::DATA_W-1:0]       pwdata,
   output logic [rrstc_pkg::DATA_W-1:0]       prdata,
   output logic                               pready
);

   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   rrstc_pkg::cfg_type              cfg;
   logic                            wr_en;
   logic [ADDR_W-1:0]               wr_addr;
   logic [rrstc_pkg::ENTRY_W-1:0]   wr_data;
   logic [ADDR_W-1:0]               rd_addr_a;
   logic [ADDR_W-1:0]               rd_addr_b;
   logic [rrstc_pkg::ENTRY_W-1:0]   rd_data_a;
   logic [rrstc_pkg::ENTRY_W-1:0]   rd_data_b;

   rrstc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rrstc_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   rrstc_ctrl #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .ADDR_W   (ADDR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cfg       (cfg),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

endmodule

FILE: sv/rrstc_csr.sv
// Configuration register file behind the APB-style port.
module rrstc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rrstc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [rrstc_pkg::DATA_W-1:0]        pwdata,
   output logic [rrstc_pkg::DATA_W-1:0]        prdata,
   output logic                                pready,
   output rrstc_pkg::cfg_type                  cfg
);

   logic signed [rrstc_pkg::DATA_W-1:0] threshold_ff, threshold_in;
   logic [rrstc_pkg::ROW_W-1:0]         row_count_ff, row_count_in;
   logic [rrstc_pkg::COL_W-1:0]         col_count_ff, col_count_in;
   logic                                write_en;
   logic [1:0]                          reg_index;

   assign pready    = 1'b1;
   assign write_en  = psel & penable & pwrite;
   assign reg_index = paddr[3:2];

   always_comb begin
      threshold_in = threshold_ff;
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      prdata       = '0;
      unique case (reg_index)
         rrstc_pkg::REG_THRESHOLD: begin
            prdata = threshold_ff;
            if (write_en) threshold_in = pwdata;
         end
         rrstc_pkg::REG_ROW_COUNT: begin
            prdata = rrstc_pkg::DATA_W'(row_count_ff);
            if (write_en) row_count_in = pwdata[rrstc_pkg::ROW_W-1:0];
         end
         rrstc_pkg::REG_COL_COUNT: begin
            prdata = rrstc_pkg::DATA_W'(col_count_ff);
            if (write_en) col_count_in = pwdata[rrstc_pkg::COL_W-1:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         row_count_ff <= rrstc_pkg::ROW_W'(1);
         col_count_ff <= rrstc_pkg::COL_W'(1);
      end else begin
         threshold_ff <= threshold_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   assign cfg.threshold = threshold_ff;
   assign cfg.row_count = row_count_ff;
   assign cfg.col_count = col_count_ff;

endmodule

FILE: sv/rrstc_mem.sv
// Prefix table memory with one write port and two registered read ports.
module rrstc_mem #(
   parameter int DEPTH  = rrstc_pkg::DEF_MAX_ROWS * rrstc_pkg::DEF_MAX_COLS,
   parameter int ADDR_W = 17
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [ADDR_W-1:0]                  wr_addr,
   input  logic [rrstc_pkg::ENTRY_W-1:0]      wr_data,
   input  logic [ADDR_W-1:0]                  rd_addr_a,
   input  logic [ADDR_W-1:0]                  rd_addr_b,
   output logic [rrstc_pkg::ENTRY_W-1:0]      rd_data_a,
   output logic [rrstc_pkg::ENTRY_W-1:0]      rd_data_b
);

   logic [rrstc_pkg::ENTRY_W-1:0] entry_ff [DEPTH];
   logic [rrstc_pkg::ENTRY_W-1:0] rd_data_a_ff;
   logic [rrstc_pkg::ENTRY_W-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= entry_ff[rd_addr_a];
      rd_data_b_ff <= entry_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

FILE: sv/rrstc_ctrl.sv
// Sequencer that runs loads and row-by-row range queries against the prefix table.
module rrstc_ctrl #(
   parameter int MAX_ROWS = rrstc_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = rrstc_pkg::DEF_MAX_COLS,
   parameter int ADDR_W   = 17
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  rrstc_pkg::req_type                 req_data,
   output logic                               rsp_valid,
   output rrstc_pkg::rsp_type                 rsp_data,
   input  rrstc_pkg::cfg_type                 cfg,
   output logic                               wr_en,
   output logic [ADDR_W-1:0]                  wr_addr,
   output logic [rrstc_pkg::ENTRY_W-1:0]      wr_data,
   output logic [ADDR_W-1:0]                  rd_addr_a,
   output logic [ADDR_W-1:0]                  rd_addr_b,
   input  logic [rrstc_pkg::ENTRY_W-1:0]      rd_data_a,
   input  logic [rrstc_pkg::ENTRY_W-1:0]      rd_data_b
);

   localparam int ROW_W   = rrstc_pkg::ROW_W;
   localparam int COL_W   = rrstc_pkg::COL_W;
   localparam int CNT_W   = rrstc_pkg::CNT_W;
   localparam int ENTRY_W = rrstc_pkg::ENTRY_W;
   localparam int VAL_W   = rrstc_pkg::VAL_W;
   localparam int DATA_W  = rrstc_pkg::DATA_W;
   localparam int ROW_LIM = (MAX_ROWS < (2 ** ROW_W) - 1) ? MAX_ROWS : (2 ** ROW_W) - 1;
   localparam int COL_LIM = (MAX_COLS < (2 ** COL_W) - 1) ? MAX_COLS : (2 ** COL_W) - 1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_LOAD  = 4'b0010,
      ST_QUERY = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

   function automatic logic [ADDR_W-1:0] entry_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
      return ADDR_W'(32'(r) * 32'(MAX_COLS) + 32'(c));
   endfunction

   state_type            state_ff, state_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [ROW_W-1:0]     rows_ff, rows_in;
   logic [COL_W-1:0]     lidx_ff, lidx_in;
   logic [COL_W-1:0]     ridx_ff, ridx_in;
   logic                 lzero_ff, lzero_in;
   logic                 empty_ff, empty_in;
   logic [CNT_W-1:0]     above_ff, above_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic                 diff_vld_ff, diff_vld_in;
   logic signed [ENTRY_W:0] diff_ff, diff_in;
   logic [ADDR_W-1:0]    ld_addr_ff, ld_addr_in;
   logic                 ld_first_ff, ld_first_in;
   logic [VAL_W-1:0]     ld_value_ff, ld_value_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rrstc_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic [ROW_W-1:0]     rows_used;
   logic [COL_W-1:0]     cols_used;
   logic [COL_W-1:0]     left_adj;
   logic [COL_W-1:0]     right_adj;
   logic                 load_ok;
   logic [ENTRY_W:0]     ext_a;
   logic [ENTRY_W:0]     ext_b;
   logic signed [DATA_W-1:0] diff_wide;

   assign rows_used = (cfg.row_count > ROW_W'(ROW_LIM)) ? ROW_W'(ROW_LIM) : cfg.row_count;
   assign cols_used = (cfg.col_count > COL_W'(COL_LIM)) ? COL_W'(COL_LIM) : cfg.col_count;
   assign left_adj  = (req_data.left == '0) ? COL_W'(1) : req_data.left;
   assign right_adj = (req_data.right > cols_used) ? cols_used : req_data.right;
   assign load_ok   = (req_data.row != '0) && (req_data.row <= rows_used) &&
                      (req_data.col != '0) && (req_data.col <= cols_used);
   assign ext_a     = {rd_data_a[ENTRY_W-1], rd_data_a};
   assign ext_b     = lzero_ff ? '0 : {rd_data_b[ENTRY_W-1], rd_data_b};
   assign diff_wide = $signed({{(DATA_W-ENTRY_W-1){diff_ff[ENTRY_W]}}, diff_ff});

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      rows_in      = rows_ff;
      lidx_in      = lidx_ff;
      ridx_in      = ridx_ff;
      lzero_in     = lzero_ff;
      empty_in     = empty_ff;
      above_in     = above_ff;
      ld_addr_in   = ld_addr_ff;
      ld_first_in  = ld_first_ff;
      ld_value_in  = ld_value_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rd_vld_in    = (state_ff == ST_QUERY);
      diff_vld_in  = rd_vld_ff;
      diff_in      = diff_ff;
      wr_en        = 1'b0;
      wr_addr      = ld_addr_ff;
      wr_data      = (ld_first_ff ? '0 : rd_data_a) +
                     {{(ENTRY_W-VAL_W){ld_value_ff[VAL_W-1]}}, ld_value_ff};
      rd_addr_a    = entry_addr(req_data.row - ROW_W'(1), req_data.col - COL_W'(2));
      rd_addr_b    = entry_addr(row_ff, lidx_ff);

      if (rd_vld_ff) begin
         diff_in = empty_ff ? '0 : $signed(ext_a - ext_b);
      end
      if (diff_vld_ff && (diff_wide > cfg.threshold)) begin
         above_in = above_ff + CNT_W'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_data.action == rrstc_pkg::ACT_LOAD) begin
                  if (load_ok) begin
                     ld_addr_in  = entry_addr(req_data.row - ROW_W'(1),
                                              req_data.col - COL_W'(1));
                     ld_first_in = (req_data.col == COL_W'(1));
                     ld_value_in = req_data.value;
                     state_in    = ST_LOAD;
                  end
               end else if (rows_used == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
               end else begin
                  row_in   = '0;
                  rows_in  = rows_used;
                  above_in = '0;
                  lidx_in  = left_adj - COL_W'(2);
                  ridx_in  = right_adj - COL_W'(1);
                  lzero_in = (left_adj == COL_W'(1));
                  empty_in = (left_adj > right_adj);
                  state_in = ST_QUERY;
               end
            end
         end
         ST_LOAD: begin
            wr_en    = 1'b1;
            state_in = ST_IDLE;
         end
         ST_QUERY: begin
            rd_addr_a = entry_addr(row_ff, ridx_ff);
            row_in    = row_ff + ROW_W'(1);
            if (row_ff == rows_ff - ROW_W'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !diff_vld_ff) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.above_count     = above_ff;
               rsp_data_in.not_above_count = rows_ff - above_ff;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         diff_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         diff_vld_ff  <= diff_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      rows_ff     <= rows_in;
      lidx_ff     <= lidx_in;
      ridx_ff     <= ridx_in;
      lzero_ff    <= lzero_in;
      empty_ff    <= empty_in;
      above_ff    <= above_in;
      diff_ff     <= diff_in;
      ld_addr_ff  <= ld_addr_in;
      ld_first_ff <= ld_first_in;
      ld_value_ff <= ld_value_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
